/* rtl/asnm_pkg.sv */
// Shared types, constants and register codes for the axis snap nearest-match block.
package asnm_pkg;

    localparam int CoordW   = 32;
    localparam int DistW    = CoordW + 1;
    localparam int TolW     = 31;
    localparam int KindW    = 2;
    localparam int CfgIdxW  = 3;
    localparam int MergeLsb = 6;

    localparam logic [KindW-1:0] KIND_NONE     = 2'd0;
    localparam logic [KindW-1:0] KIND_EDGE     = 2'd0;
    localparam logic [KindW-1:0] KIND_ENDPOINT = 2'd1;
    localparam logic [KindW-1:0] KIND_MIDPOINT = 2'd2;
    localparam logic [KindW-1:0] KIND_CENTER   = 2'd3;

    localparam logic [DistW-1:0] DIST_INF  = '1;
    localparam logic [TolW-1:0]  TOL_RESET = 31'd655360;

    typedef enum logic [CfgIdxW-1:0] {
        REG_BOX_MIN_X     = 3'd0,
        REG_BOX_MIN_Y     = 3'd1,
        REG_BOX_MAX_X     = 3'd2,
        REG_BOX_MAX_Y     = 3'd3,
        REG_TOLERANCE     = 3'd4,
        REG_CENTER_ENABLE = 3'd5,
        REG_SNAP_X_ENABLE = 3'd6,
        REG_SNAP_Y_ENABLE = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic                     axis;
        logic signed [CoordW-1:0] coord;
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic [KindW-1:0]         cand_kind;
        logic                     empty_req;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic                     snapped_x;
        logic signed [CoordW-1:0] delta_x;
        logic signed [CoordW-1:0] guide_x;
        logic                     snapped_y;
        logic signed [CoordW-1:0] delta_y;
        logic signed [CoordW-1:0] guide_y;
        logic [KindW-1:0]         hit_a_kind;
        logic signed [CoordW-1:0] hit_a_x;
        logic signed [CoordW-1:0] hit_a_y;
        logic [KindW-1:0]         hit_b_kind;
        logic signed [CoordW-1:0] hit_b_x;
        logic signed [CoordW-1:0] hit_b_y;
    } t_out_item;

    typedef struct packed {
        logic signed [CoordW-1:0] box_min_x;
        logic signed [CoordW-1:0] box_min_y;
        logic signed [CoordW-1:0] box_max_x;
        logic signed [CoordW-1:0] box_max_y;
        logic [TolW-1:0]          tolerance;
        logic                     center_enable;
        logic                     snap_x_enable;
        logic                     snap_y_enable;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        box_min_x:     '0,
        box_min_y:     '0,
        box_max_x:     '0,
        box_max_y:     '0,
        tolerance:     TOL_RESET,
        center_enable: 1'b0,
        snap_x_enable: 1'b1,
        snap_y_enable: 1'b1
    };

    // Best target match of one candidate, before comparison with the axis state
    typedef struct packed {
        logic                     axis;
        logic                     hit;
        logic [DistW-1:0]         distance;
        logic signed [CoordW-1:0] delta;
        logic signed [CoordW-1:0] coord;
        logic [KindW-1:0]         kind;
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic                     last;
    } t_match;

    typedef struct packed {
        logic                     found;
        logic [DistW-1:0]         distance;
        logic signed [CoordW-1:0] delta;
        logic signed [CoordW-1:0] guide;
        logic [KindW-1:0]         kind;
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
    } t_axis_best;

    localparam t_axis_best BEST_CLEAR = '{
        found:    1'b0,
        distance: DIST_INF,
        delta:    '0,
        guide:    '0,
        kind:     KIND_NONE,
        point_x:  '0,
        point_y:  '0
    };

    // Final per-query state, captured on the last request
    typedef struct packed {
        logic       snap_x;
        logic       snap_y;
        t_axis_best best_x;
        t_axis_best best_y;
    } t_snap;

endpackage

/* rtl/asnm_ifs.sv */
// Handshake channel interfaces: candidate input, result output and register writes.
interface asnm_in_if import asnm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface asnm_out_if import asnm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface asnm_cfg_if import asnm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [CoordW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/asnm_match.sv */
// Compares one candidate with the box targets of its axis and picks the nearest in tolerance.
module asnm_match import asnm_pkg::*; (
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_match   o_match
);

    logic signed [CoordW-1:0] lo;
    logic signed [CoordW-1:0] hi;
    logic signed [DistW-1:0]  sum;
    logic signed [CoordW-1:0] centre;
    logic signed [DistW-1:0]  d_lo;
    logic signed [DistW-1:0]  d_hi;
    logic signed [DistW-1:0]  d_ce;
    logic [DistW-1:0]         a_lo;
    logic [DistW-1:0]         a_hi;
    logic [DistW-1:0]         a_ce;
    logic [DistW-1:0]         tol_ext;
    logic                     in_lo;
    logic                     in_hi;
    logic                     in_ce;
    logic                     active;
    logic                     sel;
    logic [DistW-1:0]         sel_dist;
    logic signed [DistW-1:0]  sel_delta;

    always_comb begin
        lo = i_item.axis ? i_cfg.box_min_y : i_cfg.box_min_x;
        hi = i_item.axis ? i_cfg.box_max_y : i_cfg.box_max_x;
        // floor of the exact midpoint
        sum    = {lo[CoordW-1], lo} + {hi[CoordW-1], hi};
        centre = sum[DistW-1:1];

        d_lo = {i_item.coord[CoordW-1], i_item.coord} - {lo[CoordW-1], lo};
        d_hi = {i_item.coord[CoordW-1], i_item.coord} - {hi[CoordW-1], hi};
        d_ce = {i_item.coord[CoordW-1], i_item.coord} - {centre[CoordW-1], centre};
        a_lo = d_lo[DistW-1] ? DistW'(-d_lo) : DistW'(d_lo);
        a_hi = d_hi[DistW-1] ? DistW'(-d_hi) : DistW'(d_hi);
        a_ce = d_ce[DistW-1] ? DistW'(-d_ce) : DistW'(d_ce);

        tol_ext = {{(DistW-TolW){1'b0}}, i_cfg.tolerance};
        in_lo = a_lo <= tol_ext;
        in_hi = a_hi <= tol_ext;
        in_ce = i_cfg.center_enable && (a_ce <= tol_ext);

        active = !i_item.empty_req &&
                 (i_item.axis ? i_cfg.snap_y_enable : i_cfg.snap_x_enable);

        // try min, max, centre in turn; an equal distance keeps the earlier target
        sel       = in_lo;
        sel_dist  = a_lo;
        sel_delta = d_lo;
        if (in_hi && (!sel || a_hi < sel_dist)) begin
            sel       = 1'b1;
            sel_dist  = a_hi;
            sel_delta = d_hi;
        end
        if (in_ce && (!sel || a_ce < sel_dist)) begin
            sel       = 1'b1;
            sel_dist  = a_ce;
            sel_delta = d_ce;
        end

        o_match.axis     = i_item.axis;
        o_match.hit      = active && sel;
        o_match.distance = sel_dist;
        o_match.delta    = sel_delta[CoordW-1:0];
        o_match.coord    = i_item.coord;
        o_match.kind     = i_item.cand_kind;
        o_match.point_x  = i_item.point_x;
        o_match.point_y  = i_item.point_y;
        o_match.last     = i_item.last;
    end

endmodule

/* rtl/asnm_hits.sv */
// Builds the result from the final per-axis state: deltas, guides and merged snap hits.
module asnm_hits import asnm_pkg::*; (
    input  t_snap     i_snap,
    output t_out_item o_result
);

    localparam logic signed [DistW-1:0] MergeHi = DistW'(MergeLsb);
    localparam logic signed [DistW-1:0] MergeLo = -DistW'(MergeLsb);

    logic signed [DistW-1:0] dx;
    logic signed [DistW-1:0] dy;
    logic                    same;
    logic                    push_x;
    logic                    push_y;

    always_comb begin
        dx = {i_snap.best_x.point_x[CoordW-1], i_snap.best_x.point_x}
           - {i_snap.best_y.point_x[CoordW-1], i_snap.best_y.point_x};
        dy = {i_snap.best_x.point_y[CoordW-1], i_snap.best_y.point_y[CoordW-1] ^
              i_snap.best_y.point_y[CoordW-1] ^ i_snap.best_x.point_y[CoordW-1],
              i_snap.best_x.point_y[CoordW-2:0]} - {i_snap.best_y.point_y[CoordW-1],
              i_snap.best_y.point_y};
        same = (i_snap.best_y.kind != KIND_NONE) &&
               (i_snap.best_x.kind == i_snap.best_y.kind) &&
               (dx <= MergeHi) && (dx >= MergeLo) &&
               (dy <= MergeHi) && (dy >= MergeLo);

        // drop the y hit when it lands on the x hit
        push_x = i_snap.snap_x && (i_snap.best_x.kind != KIND_NONE);
        push_y = i_snap.snap_y && (i_snap.best_y.kind != KIND_NONE) &&
                 !(i_snap.snap_x && same);

        o_result = '0;
        if (i_snap.snap_x) begin
            o_result.snapped_x = 1'b1;
            o_result.delta_x   = i_snap.best_x.delta;
            o_result.guide_x   = i_snap.best_x.guide;
        end
        if (i_snap.snap_y) begin
            o_result.snapped_y = 1'b1;
            o_result.delta_y   = i_snap.best_y.delta;
            o_result.guide_y   = i_snap.best_y.guide;
        end
        if (push_x) begin
            o_result.hit_a_kind = i_snap.best_x.kind;
            o_result.hit_a_x    = i_snap.best_x.point_x;
            o_result.hit_a_y    = i_snap.best_x.point_y;
            if (push_y) begin
                o_result.hit_b_kind = i_snap.best_y.kind;
                o_result.hit_b_x    = i_snap.best_y.point_x;
                o_result.hit_b_y    = i_snap.best_y.point_y;
            end
        end else if (push_y) begin
            o_result.hit_a_kind = i_snap.best_y.kind;
            o_result.hit_a_x    = i_snap.best_y.point_x;
            o_result.hit_a_y    = i_snap.best_y.point_y;
        end
    end

endmodule

/* rtl/axis_snap_nearest_match_top.sv */
// Axis snap nearest match: candidate stream in, one snap result per query out.
//
// Channels: i_in takes one candidate request per cycle while its ready is high
// (axis, coordinate, kind, reference point, empty and last flags). o_out gives
// one result for each request marked last. i_cfg writes the box, tolerance and
// enable registers; its ready is always high. The user must write it only while
// no query is in flight; the block itself does not enforce this. Requests flow
// at one request per cycle while i_in.ready is high, through the four-stage
// pipeline: input register, target compare, per-axis best update, hit merge into
// the output register. A query's last request passes these stages in that order.
// Reset clears the pipeline valids and the per-axis best state and loads the
// register defaults (box 0, tolerance 10.0, centre off, both axes on). The
// best state is cleared again after every last request.
// When the receiver stalls, the output register holds its result and the
// snapshot stage takes one more; requests keep flowing into the best state
// until a further last request waits at the best-update stage with another
// request behind it in the input register, at which point i_in.ready falls.
module axis_snap_nearest_match_top import asnm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    asnm_cfg_if.sink      i_cfg,
    asnm_in_if.sink       i_in,
    asnm_out_if.source    o_out
);

    t_cfg       r_cfg;
    logic       r_v1;
    t_in_item   r_s1;
    logic       r_v2;
    t_match     r_s2;
    logic       r_v3;
    t_snap      r_s3;
    logic       r_vo;
    t_out_item  r_out;
    t_axis_best r_best_x;
    t_axis_best r_best_y;

    t_match     s1_match;
    t_out_item  s3_result;
    t_axis_best cur;
    t_axis_best upd;
    t_axis_best n_best_x;
    t_axis_best n_best_y;
    t_snap      n_snap;
    logic       en_o;
    logic       en3;
    logic       en2;
    logic       en1;
    logic       fire2;

    asnm_match u_match (
        .i_item  (r_s1),
        .i_cfg   (r_cfg),
        .o_match (s1_match)
    );

    asnm_hits u_hits (
        .i_snap   (r_s3),
        .o_result (s3_result)
    );

    // a stage loads when it is empty or its content moves on
    assign en_o  = !r_vo || o_out.ready;
    assign en3   = !r_v3 || en_o;
    assign en2   = !r_v2 || !r_s2.last || en3;
    assign en1   = !r_v1 || en2;
    assign fire2 = r_v2 && en2;

    assign i_in.ready  = en1;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_vo;
    assign o_out.data  = r_out;

    always_comb begin
        cur = r_s2.axis ? r_best_y : r_best_x;
        upd = cur;
        if (r_s2.hit && (r_s2.distance < cur.distance)) begin
            upd.found    = 1'b1;
            upd.distance = r_s2.distance;
            upd.delta    = r_s2.delta;
            upd.guide    = r_s2.coord;
            upd.kind     = r_s2.kind;
            upd.point_x  = r_s2.point_x;
            upd.point_y  = r_s2.point_y;
        end
        n_best_x = r_s2.axis ? r_best_x : upd;
        n_best_y = r_s2.axis ? upd : r_best_y;

        n_snap.snap_x = r_cfg.snap_x_enable && n_best_x.found;
        n_snap.snap_y = r_cfg.snap_y_enable && n_best_y.found;
        n_snap.best_x = n_best_x;
        n_snap.best_y = n_best_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CFG_RESET;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_vo     <= 1'b0;
            r_best_x <= BEST_CLEAR;
            r_best_y <= BEST_CLEAR;
        end else begin
            if (i_cfg.valid) begin
                unique case (t_reg_idx'(i_cfg.index))
                    REG_BOX_MIN_X:     r_cfg.box_min_x     <= i_cfg.data;
                    REG_BOX_MIN_Y:     r_cfg.box_min_y     <= i_cfg.data;
                    REG_BOX_MAX_X:     r_cfg.box_max_x     <= i_cfg.data;
                    REG_BOX_MAX_Y:     r_cfg.box_max_y     <= i_cfg.data;
                    REG_TOLERANCE:     r_cfg.tolerance     <= i_cfg.data[TolW-1:0];
                    REG_CENTER_ENABLE: r_cfg.center_enable <= i_cfg.data[0];
                    REG_SNAP_X_ENABLE: r_cfg.snap_x_enable <= i_cfg.data[0];
                    REG_SNAP_Y_ENABLE: r_cfg.snap_y_enable <= i_cfg.data[0];
                    default: ;
                endcase
            end
            if (en1) begin
                r_v1 <= i_in.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= fire2 && r_s2.last;
            end
            if (en_o) begin
                r_vo <= r_v3;
            end
            // advance the best state; a last request starts the next query clean
            if (fire2) begin
                if (r_s2.last) begin
                    r_best_x <= BEST_CLEAR;
                    r_best_y <= BEST_CLEAR;
                end else begin
                    r_best_x <= n_best_x;
                    r_best_y <= n_best_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= i_in.data;
        end
        if (en2) begin
            r_s2 <= s1_match;
        end
        if (en3) begin
            r_s3 <= n_snap;
        end
        if (en_o) begin
            r_out <= s3_result;
        end
    end

endmodule

/* rtl/asnm_checker.sv */
// Port-level checks on the result channel, bound to the top level.
module asnm_checker import asnm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed or dropped while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown straight after reset");

    a_hit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.hit_b_kind != KIND_NONE)
            |-> (i_out_data.hit_a_kind != KIND_NONE))
        else $error("second hit slot used while first is empty");

    a_hit_needs_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.hit_a_kind != KIND_NONE)
            |-> (i_out_data.snapped_x || i_out_data.snapped_y))
        else $error("hit reported without any axis snapped");

    a_unsnapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.snapped_x
            |-> (i_out_data.delta_x == '0) && (i_out_data.guide_x == '0))
        else $error("unsnapped x axis carries a delta or guide");

endmodule

bind axis_snap_nearest_match_top asnm_checker u_asnm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
